// ----- hw/rtl/text_terminal_char_engine_assert.svh -----
// Assertion macros used by the terminal engine top level.
`ifndef TEXT_TERMINAL_CHAR_ENGINE_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TTCE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/ttce_pkg.sv -----
// Types and constants of the text terminal character engine.
`timescale 1ns / 1ps
`default_nettype none

package ttce_pkg;

   localparam int FB_ADDR_W = 12;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic CSR_ATTRIBUTE_MASK = 1'b0;
   localparam logic CSR_BOLD_MASK      = 1'b1;

   localparam logic [7:0] CH_NUL = 8'd0;
   localparam logic [7:0] CH_BEL = 8'd7;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_FF  = 8'd12;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_ESC = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] POS_BIAS = 8'd32;

   localparam logic [7:0] ESC_ATTR      = 8'h61;
   localparam logic [7:0] ESC_POS       = 8'h59;
   localparam logic [7:0] ESC_SHOW      = 8'h65;
   localparam logic [7:0] ESC_HIDE      = 8'h66;
   localparam logic [7:0] ESC_BOLD_ON   = 8'h70;
   localparam logic [7:0] ESC_BOLD_OFF  = 8'h71;
   localparam logic [7:0] ESC_WRAP_ON   = 8'h76;
   localparam logic [7:0] ESC_WRAP_OFF  = 8'h77;
   localparam logic [7:0] ESC_UP        = 8'h41;
   localparam logic [7:0] ESC_DOWN      = 8'h42;
   localparam logic [7:0] ESC_RIGHT     = 8'h43;
   localparam logic [7:0] ESC_LEFT      = 8'h44;
   localparam logic [7:0] ESC_CLEAR     = 8'h45;

   localparam logic [7:0] ATTR_RESET      = 8'h07;
   localparam logic [7:0] ATTR_MASK_RESET = 8'hFF;
   localparam logic [7:0] BOLD_MASK_RESET = 8'h08;

   typedef struct packed {
      logic        operation;
      logic [7:0]  char_byte;
      logic [10:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [10:0] cursor_position;
      logic        cursor_shown;
      logic        bell;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [FB_ADDR_W-1:0] addr;
      logic [15:0]          wdata;
      logic                 scroll;
      logic                 clear;
   } fb_cmd_type;

   typedef enum logic [3:0] {
      ST_INIT   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [4:0] {
      SEQ_NORMAL = 5'b00001,
      SEQ_ESC    = 5'b00010,
      SEQ_ROW    = 5'b00100,
      SEQ_COL    = 5'b01000,
      SEQ_ATTR   = 5'b10000
   } seq_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ttce_frame.sv -----
// Framebuffer memory with the clear and scroll sweep engine.
`timescale 1ns / 1ps
`default_nettype none

module ttce_frame #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ttce_pkg::fb_cmd_type cmd,
   input  wire logic [15:0]         blank,
   output logic                     busy,
   output logic [15:0]              rdata
);
   import ttce_pkg::*;

   localparam int Cells   = COLUMNS * ROWS;
   localparam int AddrW   = $clog2(Cells);
   localparam int CopyEnd = Cells - COLUMNS;
   localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
   localparam logic [AddrW-1:0] CopyEndA = AddrW'(CopyEnd);
   localparam logic [AddrW-1:0] ColsA    = AddrW'(COLUMNS);

   logic [15:0]      mem [Cells];
   logic [15:0]      rdata_ff;
   logic             sweep_ff, sweep_in;
   logic             scroll_ff, scroll_in;
   logic [AddrW-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic             pend_copy_ff, pend_copy_in;
   logic [AddrW-1:0] pend_addr_ff, pend_addr_in;
   logic             copy_rd;

   assign copy_rd = sweep_ff && scroll_ff && (idx_ff < CopyEndA);

   always_comb begin
      sweep_in     = sweep_ff;
      scroll_in    = scroll_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_copy_in = pend_copy_ff;
      pend_addr_in = pend_addr_ff;
      if (sweep_ff) begin
         pend_in      = 1'b1;
         pend_addr_in = idx_ff;
         pend_copy_in = copy_rd;
         if (idx_ff == LastCell) begin
            sweep_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (cmd.scroll || cmd.clear) begin
         sweep_in  = 1'b1;
         scroll_in = cmd.scroll;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= 1'b1;
         scroll_ff <= 1'b0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         sweep_ff  <= sweep_in;
         scroll_ff <= scroll_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
      end
      pend_copy_ff <= pend_copy_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         mem[pend_addr_ff] <= pend_copy_ff ? rdata_ff : blank;
      end else if (cmd.wr_en) begin
         mem[AddrW'(cmd.addr)] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (copy_rd) begin
         rdata_ff <= mem[idx_ff + ColsA];
      end else if (cmd.rd_en) begin
         rdata_ff <= mem[AddrW'(cmd.addr)];
      end
   end

   assign busy  = sweep_ff || pend_ff;
   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/text_terminal_char_engine.sv -----
// Top level of the text terminal character engine.
//
//   port group   dir   handshake          beat
//   req_*        in    req_valid/stall    one byte to put or one cell to read
//   rsp_*        out   rsp_valid/stall    cell data, cursor, cursor shown, bell
//   csr_*        in    csr_write          one mask register, no read-back
//
// Read, plain put, control and escape bytes: accept to ST_FINISH, then the result register.
// Clear (FF, ESC E) and scroll: ST_WAIT holds through a sweep of all COLUMNS*ROWS cells.
// Reset starts a clearing pass over all COLUMNS*ROWS cells; req_stall is high during it.
// The result register parts the sides: the next beat is accepted while a
// result waits; a finished item waits for the result register to free.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_char_engine #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ttce_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ttce_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_data
);
   import ttce_pkg::*;

   `include "text_terminal_char_engine_assert.svh"

   localparam int Cells = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AddrW = $clog2(Cells);
   localparam int ColW  = $clog2(SCREEN_COLUMNS);
   localparam int RowW  = $clog2(SCREEN_ROWS);
   localparam logic [ColW-1:0]  LastCol = ColW'(SCREEN_COLUMNS - 1);
   localparam logic [RowW-1:0]  LastRow = RowW'(SCREEN_ROWS - 1);
   localparam logic [AddrW-1:0] ColsA   = AddrW'(SCREEN_COLUMNS);
   localparam logic [7:0]       ColsB   = 8'(SCREEN_COLUMNS);
   localparam logic [7:0]       RowsB   = 8'(SCREEN_ROWS);
   localparam logic [12:0]      CellsW  = 13'(Cells);

   state_type       state_ff, state_in;
   seq_type         seq_ff, seq_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [7:0]      attr_ff, attr_in;
   logic            vis_ff, vis_in;
   logic            wrap_ff, wrap_in;
   logic [7:0]      amask_ff, amask_in;
   logic [7:0]      bmask_ff, bmask_in;
   logic            bell_ff, bell_in;
   logic            read_ff, read_in;
   logic            hit_ff, hit_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   fb_cmd_type      fb_cmd;
   logic            fb_busy;
   logic [15:0]     fb_rdata;
   logic [AddrW-1:0] cur_addr;
   logic            accept;
   logic            slot_free;
   logic            line_down;
   logic            home;
   logic [7:0]      c;

   function automatic logic [7:0] clamp_pos(logic [7:0] b, logic [7:0] limit);
      logic [7:0] off;
      off = b - POS_BIAS;
      if (b < POS_BIAS) begin
         return 8'd0;
      end
      return (off >= limit) ? (limit - 8'd1) : off;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cur_addr  = AddrW'(row_ff) * ColsA + AddrW'(col_ff);
   assign c         = req_payload.char_byte;

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      attr_in   = attr_ff;
      vis_in    = vis_ff;
      wrap_in   = wrap_ff;
      seq_in    = seq_ff;
      bell_in   = bell_ff;
      read_in   = read_ff;
      hit_in    = hit_ff;
      fb_cmd    = '0;
      line_down = 1'b0;
      home      = 1'b0;
      if (accept) begin
         bell_in = 1'b0;
         read_in = (req_payload.operation == OP_READ);
         hit_in  = ({2'b00, req_payload.cell_address} < CellsW);
         if (req_payload.operation == OP_READ) begin
            fb_cmd.rd_en = 1'b1;
            fb_cmd.addr  = FB_ADDR_W'(req_payload.cell_address);
         end else begin
            unique case (seq_ff)
               SEQ_ESC: begin
                  seq_in = SEQ_NORMAL;
                  unique case (c)
                     ESC_ATTR:     seq_in  = SEQ_ATTR;
                     ESC_POS:      seq_in  = SEQ_ROW;
                     ESC_SHOW:     vis_in  = 1'b1;
                     ESC_HIDE:     vis_in  = 1'b0;
                     ESC_BOLD_ON:  attr_in = attr_ff | bmask_ff;
                     ESC_BOLD_OFF: attr_in = attr_ff & ~bmask_ff;
                     ESC_WRAP_ON:  wrap_in = 1'b1;
                     ESC_WRAP_OFF: wrap_in = 1'b0;
                     ESC_UP: begin
                        if (row_ff != '0) row_in = row_ff - 1'b1;
                     end
                     ESC_DOWN: begin
                        if (row_ff != LastRow) row_in = row_ff + 1'b1;
                     end
                     ESC_RIGHT: begin
                        if (col_ff != LastCol) col_in = col_ff + 1'b1;
                     end
                     ESC_LEFT: begin
                        if (col_ff != '0) col_in = col_ff - 1'b1;
                     end
                     ESC_CLEAR:    home = 1'b1;
                     default: ;
                  endcase
               end
               SEQ_ROW: begin
                  row_in = RowW'(clamp_pos(c, RowsB));
                  seq_in = SEQ_COL;
               end
               SEQ_COL: begin
                  col_in = ColW'(clamp_pos(c, ColsB));
                  seq_in = SEQ_NORMAL;
               end
               SEQ_ATTR: begin
                  attr_in = c & amask_ff;
                  seq_in  = SEQ_NORMAL;
               end
               default: begin
                  seq_in = SEQ_NORMAL;
                  unique case (c)
                     CH_NUL: ;
                     CH_BEL: bell_in = 1'b1;
                     CH_BS: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                        end else if (wrap_ff && row_ff != '0) begin
                           col_in = LastCol;
                           row_in = row_ff - 1'b1;
                        end
                     end
                     CH_LF:  line_down = 1'b1;
                     CH_FF:  home      = 1'b1;
                     CH_CR:  col_in    = '0;
                     CH_ESC: seq_in    = SEQ_ESC;
                     default: begin
                        fb_cmd.wr_en = 1'b1;
                        fb_cmd.addr  = FB_ADDR_W'(cur_addr);
                        fb_cmd.wdata = {attr_ff, c};
                        if (col_ff == LastCol) begin
                           if (wrap_ff) begin
                              col_in    = '0;
                              line_down = 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  endcase
               end
            endcase
         end
      end
      if (line_down) begin
         if (row_ff == LastRow) begin
            fb_cmd.scroll = 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
      if (home) begin
         fb_cmd.clear = 1'b1;
         col_in       = '0;
         row_in       = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (!fb_busy) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (fb_cmd.scroll || fb_cmd.clear) ? ST_WAIT : ST_FINISH;
            end
         end
         ST_WAIT: begin
            if (!fb_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_valid_in           = 1'b1;
         rsp_in.cell_data       = (read_ff && hit_ff) ? fb_rdata : 16'h0000;
         rsp_in.cursor_position = 11'(cur_addr);
         rsp_in.cursor_shown    = vis_ff;
         rsp_in.bell            = bell_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      amask_in = amask_ff;
      bmask_in = bmask_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ATTRIBUTE_MASK: amask_in = csr_data;
            CSR_BOLD_MASK:      bmask_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         seq_ff       <= SEQ_NORMAL;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         vis_ff       <= 1'b1;
         wrap_ff      <= 1'b1;
         amask_ff     <= ATTR_MASK_RESET;
         bmask_ff     <= BOLD_MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         vis_ff       <= vis_in;
         wrap_ff      <= wrap_in;
         amask_ff     <= amask_in;
         bmask_ff     <= bmask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bell_ff <= bell_in;
      read_ff <= read_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   ttce_frame #(
      .COLUMNS (SCREEN_COLUMNS),
      .ROWS    (SCREEN_ROWS)
   ) u_frame (
      .clock (clock),
      .reset (reset),
      .cmd   (fb_cmd),
      .blank ({attr_ff, CH_SPACE}),
      .busy  (fb_busy),
      .rdata (fb_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `TTCE_ASSERT_IMP(a_cursor_range, clock, reset, 1'b1,
      (col_ff <= LastCol) && (row_ff <= LastRow))
   `TTCE_ASSERT_IMP(a_busy_blocks_req, clock, reset, fb_busy, req_stall)
   `TTCE_ASSERT_NXT(a_read_finishes, clock, reset,
      accept && (req_payload.operation == OP_READ), state_ff == ST_FINISH)
   `TTCE_ASSERT_NXT(a_finish_loads_rsp, clock, reset,
      (state_ff == ST_FINISH) && slot_free, rsp_valid)
   `TTCE_ASSERT_IMP(a_bell_no_data, clock, reset,
      rsp_valid && rsp_payload.bell, rsp_payload.cell_data == 16'h0000)

endmodule

`default_nettype wire
